### src/bale_pkg.sv
// Shared types, codes and defaults for the bounded array list engine.
`default_nettype none
package bale_pkg;

   localparam int CAPACITY_DEF     = 32;
   localparam int ELEMENT_BITS_DEF = 8;
   localparam int KIND_W           = 4;
   localparam int STATUS_W         = 2;

   localparam logic [KIND_W-1:0] KIND_CLEAR    = 4'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT   = 4'd2;
   localparam logic [KIND_W-1:0] KIND_DELETE   = 4'd3;
   localparam logic [KIND_W-1:0] KIND_FIND     = 4'd4;
   localparam logic [KIND_W-1:0] KIND_FIND_TR  = 4'd5;
   localparam logic [KIND_W-1:0] KIND_FIND_MTF = 4'd6;
   localparam logic [KIND_W-1:0] KIND_BIN_FIND = 4'd7;
   localparam logic [KIND_W-1:0] KIND_REVERSE  = 4'd8;
   localparam logic [KIND_W-1:0] KIND_SORTED   = 4'd9;
   localparam logic [KIND_W-1:0] KIND_PARTIT   = 4'd10;
   localparam logic [KIND_W-1:0] KIND_READ     = 4'd11;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;

   typedef enum logic [2:0] {
      A_HOLD, A_ZERO, A_POS, A_CNT, A_INC, A_DEC, A_MIDP1
   } a_op_type;

   typedef enum logic [3:0] {
      B_HOLD, B_ZERO, B_CNT, B_CNTM1, B_POSP1, B_AM1, B_DEC, B_INC, B_MID
   } b_op_type;

   typedef enum logic [1:0] {C_HOLD, C_ZERO, C_INC, C_DEC} cnt_op_type;
   typedef enum logic [1:0] {AD_A, AD_B, AD_MID} addr_sel_type;
   typedef enum logic [1:0] {WD_VAL, WD_Q, WD_T1} wdat_sel_type;
   typedef enum logic {WH_A, WH_MID} where_sel_type;

   typedef struct packed {
      logic                load_req;
      logic                rd_en;
      addr_sel_type        rd_sel;
      logic                wr_en;
      addr_sel_type        wr_sel;
      wdat_sel_type        wd_sel;
      a_op_type            a_op;
      b_op_type            b_op;
      cnt_op_type          cnt_op;
      logic                t1_load;
      logic                set_status;
      logic [STATUS_W-1:0] status_val;
      logic                where_load;
      where_sel_type       where_sel;
      logic                read_load;
      logic                sorted_set;
      logic                sorted_val;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic pos_le_cnt;
      logic pos_lt_cnt;
      logic a_gt_pos;
      logic a_lt_cnt;
      logic b_lt_cnt;
      logic a_lt_b;
      logic rev_go;
      logic a_nz;
      logic a_p1_lt_cnt;
      logic cnt_le1;
      logic q_eq_val;
      logic q_gt_val;
      logic q_neg;
      logic t1_gt_q;
   } flag_type;

endpackage
`default_nettype wire

### src/bounded_array_list_engine.sv
// Bounded array list engine: an ordered list of signed elements with list operations.
// Each operation ends with a sorted scan of the live elements before rsp_tvalid rises; the
// store has one read port. One item is in work at a time; the engine is ready for the next
// beat in the cycle after the result is registered, which waits while rsp_tready holds back
// the previous result. Reset empties the list; stored elements stay.
`default_nettype none
module bounded_array_list_engine #(
   parameter int CAPACITY     = bale_pkg::CAPACITY_DEF,
   parameter int ELEMENT_BITS = bale_pkg::ELEMENT_BITS_DEF,
   localparam int IDX_W  = $clog2(CAPACITY),
   localparam int CNT_W  = $clog2(CAPACITY + 1),
   localparam int REQ_DW = ((IDX_W + ELEMENT_BITS + 7) / 8) * 8,
   localparam int RSP_DW = ((bale_pkg::STATUS_W + IDX_W + ELEMENT_BITS + 1 + CNT_W + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [REQ_DW-1:0]           req_tdata,  // position_in, element_in
   input  logic [bale_pkg::KIND_W-1:0] req_tuser,  // kind
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RSP_DW-1:0]           rsp_tdata   // status, position_out, element_out,
                                                   // is_sorted, count
);
   import bale_pkg::*;

   cmd_type                 cmd;
   flag_type                flags;
   logic [STATUS_W-1:0]     rsp_status;
   logic [IDX_W-1:0]        rsp_position;
   logic [ELEMENT_BITS-1:0] rsp_element;
   logic                    rsp_sorted;
   logic [CNT_W-1:0]        rsp_count;

   bale_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .flags      (flags)
   );

   bale_dpath #(.CAPACITY(CAPACITY), .ELEMENT_BITS(ELEMENT_BITS)) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .flags        (flags),
      .req_position (req_tdata[IDX_W-1:0]),
      .req_element  (req_tdata[IDX_W+ELEMENT_BITS-1:IDX_W]),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_element  (rsp_element),
      .rsp_sorted   (rsp_sorted),
      .rsp_count    (rsp_count)
   );

   assign rsp_tdata = RSP_DW'({rsp_count, rsp_sorted, rsp_element, rsp_position, rsp_status});

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= CNT_W'(CAPACITY))
      else $error("live count beyond capacity");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == ST_OK || rsp_status == ST_RANGE || rsp_status == ST_MISS))
      else $error("undefined status code");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat taken while an item is in work");

   a_miss_no_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_MISS) |-> rsp_position == '0)
      else $error("position reported for a missed search");
endmodule
`default_nettype wire

### src/bale_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bale_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### src/bale_dpath.sv
// Datapath: element store, walk pointers, live count and the result register.
`default_nettype none
module bale_dpath #(
   parameter int CAPACITY     = bale_pkg::CAPACITY_DEF,
   parameter int ELEMENT_BITS = bale_pkg::ELEMENT_BITS_DEF,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bale_pkg::cmd_type             cmd,
   output bale_pkg::flag_type            flags,
   input  logic [IDX_W-1:0]              req_position,
   input  logic [ELEMENT_BITS-1:0]       req_element,
   output logic [bale_pkg::STATUS_W-1:0] rsp_status,
   output logic [IDX_W-1:0]              rsp_position,
   output logic [ELEMENT_BITS-1:0]       rsp_element,
   output logic                          rsp_sorted,
   output logic [CNT_W-1:0]              rsp_count
);
   import bale_pkg::*;

   logic [IDX_W-1:0]        pos_ff;
   logic [ELEMENT_BITS-1:0] val_ff, t1_ff, rdval_ff, q;
   logic [CNT_W-1:0]        a_ff, a_in, b_ff, b_in, cnt_ff, cnt_in, mid, pos_w;
   logic [CNT_W:0]          mid_sum, a_p1;
   logic [STATUS_W-1:0]     status_ff;
   logic [IDX_W-1:0]        where_ff;
   logic                    sorted_ff;
   logic [IDX_W-1:0]        rd_addr, wr_addr;
   logic [ELEMENT_BITS-1:0] wr_data;
   logic [STATUS_W-1:0]     out_status_ff;
   logic [IDX_W-1:0]        out_pos_ff;
   logic [ELEMENT_BITS-1:0] out_elem_ff;
   logic                    out_sorted_ff;
   logic [CNT_W-1:0]        out_cnt_ff;

   assign pos_w   = CNT_W'(pos_ff);
   assign mid_sum = {1'b0, a_ff} + {1'b0, b_ff} - (CNT_W+1)'(1);
   assign mid     = mid_sum[CNT_W:1];
   assign a_p1    = {1'b0, a_ff} + (CNT_W+1)'(1);

   always_comb begin
      unique case (cmd.rd_sel)
         AD_A:    rd_addr = a_ff[IDX_W-1:0];
         AD_B:    rd_addr = b_ff[IDX_W-1:0];
         default: rd_addr = mid[IDX_W-1:0];
      endcase
      wr_addr = (cmd.wr_sel == AD_B) ? b_ff[IDX_W-1:0] : a_ff[IDX_W-1:0];
      unique case (cmd.wd_sel)
         WD_VAL:  wr_data = val_ff;
         WD_Q:    wr_data = q;
         default: wr_data = t1_ff;
      endcase
   end

   bale_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (q)
   );

   always_comb begin
      unique case (cmd.a_op)
         A_ZERO:  a_in = '0;
         A_POS:   a_in = pos_w;
         A_CNT:   a_in = cnt_ff;
         A_INC:   a_in = a_ff + CNT_W'(1);
         A_DEC:   a_in = a_ff - CNT_W'(1);
         A_MIDP1: a_in = mid + CNT_W'(1);
         default: a_in = a_ff;
      endcase
      unique case (cmd.b_op)
         B_ZERO:  b_in = '0;
         B_CNT:   b_in = cnt_ff;
         B_CNTM1: b_in = (cnt_ff == '0) ? '0 : cnt_ff - CNT_W'(1);
         B_POSP1: b_in = pos_w + CNT_W'(1);
         B_AM1:   b_in = a_ff - CNT_W'(1);
         B_DEC:   b_in = b_ff - CNT_W'(1);
         B_INC:   b_in = b_ff + CNT_W'(1);
         B_MID:   b_in = mid;
         default: b_in = b_ff;
      endcase
      unique case (cmd.cnt_op)
         C_ZERO:  cnt_in = '0;
         C_INC:   cnt_in = cnt_ff + CNT_W'(1);
         C_DEC:   cnt_in = cnt_ff - CNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      if (cmd.load_req) begin
         pos_ff    <= req_position;
         val_ff    <= req_element;
         status_ff <= ST_OK;
         where_ff  <= '0;
         rdval_ff  <= '0;
      end else begin
         if (cmd.set_status) status_ff <= cmd.status_val;
         if (cmd.where_load) begin
            where_ff <= (cmd.where_sel == WH_MID) ? mid[IDX_W-1:0] : a_ff[IDX_W-1:0];
         end
         if (cmd.read_load) rdval_ff <= q;
      end
      if (cmd.t1_load) t1_ff <= q;
      if (cmd.sorted_set) sorted_ff <= cmd.sorted_val;
      if (cmd.rsp_load) begin
         out_status_ff <= status_ff;
         out_pos_ff    <= where_ff;
         out_elem_ff   <= rdval_ff;
         out_sorted_ff <= sorted_ff;
         out_cnt_ff    <= cnt_ff;
      end
   end

   always_comb begin
      flags.full        = (cnt_ff == CNT_W'(CAPACITY));
      flags.pos_le_cnt  = (pos_w <= cnt_ff);
      flags.pos_lt_cnt  = (pos_w < cnt_ff);
      flags.a_gt_pos    = (a_ff > pos_w);
      flags.a_lt_cnt    = (a_ff < cnt_ff);
      flags.b_lt_cnt    = (b_ff < cnt_ff);
      flags.a_lt_b      = (a_ff < b_ff);
      flags.rev_go      = (b_ff != '0) && (a_p1 < {1'b0, b_ff});
      flags.a_nz        = (a_ff != '0);
      flags.a_p1_lt_cnt = (a_p1 < {1'b0, cnt_ff});
      flags.cnt_le1     = (cnt_ff <= CNT_W'(1));
      flags.q_eq_val    = (q == val_ff);
      flags.q_gt_val    = ($signed(q) > $signed(val_ff));
      flags.q_neg       = q[ELEMENT_BITS-1];
      flags.t1_gt_q     = ($signed(t1_ff) > $signed(q));
   end

   assign rsp_status   = out_status_ff;
   assign rsp_position = out_pos_ff;
   assign rsp_element  = out_elem_ff;
   assign rsp_sorted   = out_sorted_ff;
   assign rsp_count    = out_cnt_ff;
endmodule
`default_nettype wire

### src/bale_ctrl.sv
// Controller: sequences each operation over the element store, at most one access a cycle.
`default_nettype none
module bale_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [bale_pkg::KIND_W-1:0] req_kind,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output bale_pkg::cmd_type           cmd,
   input  bale_pkg::flag_type          flags
);
   import bale_pkg::*;

   typedef enum logic [28:0] {
      S_IDLE    = 29'b1 << 0,
      S_DISP    = 29'b1 << 1,
      S_APP     = 29'b1 << 2,
      S_INS_CHK = 29'b1 << 3,
      S_INS_WR  = 29'b1 << 4,
      S_DEL_CHK = 29'b1 << 5,
      S_DEL_WR  = 29'b1 << 6,
      S_RD_REQ  = 29'b1 << 7,
      S_RD_WAIT = 29'b1 << 8,
      S_FND_RD  = 29'b1 << 9,
      S_FND_CMP = 29'b1 << 10,
      S_BIN_CHK = 29'b1 << 11,
      S_BIN_CMP = 29'b1 << 12,
      S_REV_CHK = 29'b1 << 13,
      S_PAR_OUT = 29'b1 << 14,
      S_PAR_RA  = 29'b1 << 15,
      S_PAR_CA  = 29'b1 << 16,
      S_PAR_RB  = 29'b1 << 17,
      S_PAR_CB  = 29'b1 << 18,
      S_SW0     = 29'b1 << 19,
      S_SW1     = 29'b1 << 20,
      S_SW2     = 29'b1 << 21,
      S_SW3     = 29'b1 << 22,
      S_SRT0    = 29'b1 << 23,
      S_SRT1    = 29'b1 << 24,
      S_SRT2    = 29'b1 << 25,
      S_SRT3    = 29'b1 << 26,
      S_SRT4    = 29'b1 << 27,
      S_FIN     = 29'b1 << 28
   } state_type;

   state_type         state_ff, state_in;
   logic [KIND_W-1:0] kind_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cmd.load_req = accept;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DISP;
         end
         S_DISP: begin
            state_in = S_SRT0;
            unique case (kind_ff)
               KIND_CLEAR: cmd.cnt_op = C_ZERO;
               KIND_APPEND: begin
                  if (flags.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = ST_RANGE;
                  end else begin
                     cmd.a_op = A_CNT;
                     state_in = S_APP;
                  end
               end
               KIND_INSERT: begin
                  if (!flags.full && flags.pos_le_cnt) begin
                     cmd.a_op = A_CNT;
                     cmd.b_op = B_CNTM1;
                     state_in = S_INS_CHK;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = ST_RANGE;
                  end
               end
               KIND_DELETE: begin
                  if (flags.pos_lt_cnt) begin
                     cmd.a_op = A_POS;
                     cmd.b_op = B_POSP1;
                     state_in = S_DEL_CHK;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = ST_RANGE;
                  end
               end
               KIND_FIND, KIND_FIND_TR, KIND_FIND_MTF: begin
                  cmd.a_op = A_ZERO;
                  state_in = S_FND_RD;
               end
               KIND_BIN_FIND: begin
                  cmd.a_op = A_ZERO;
                  cmd.b_op = B_CNT;
                  state_in = S_BIN_CHK;
               end
               KIND_REVERSE: begin
                  cmd.a_op = A_ZERO;
                  cmd.b_op = B_CNT;
                  state_in = S_REV_CHK;
               end
               KIND_PARTIT: begin
                  cmd.a_op = A_ZERO;
                  cmd.b_op = B_CNTM1;
                  state_in = S_PAR_OUT;
               end
               KIND_READ: begin
                  if (flags.pos_lt_cnt) begin
                     cmd.a_op = A_POS;
                     state_in = S_RD_REQ;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = ST_RANGE;
                  end
               end
               default: state_in = S_SRT0;
            endcase
         end
         S_APP: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = AD_A;
            cmd.wd_sel = WD_VAL;
            cmd.cnt_op = C_INC;
            state_in   = S_SRT0;
         end
         // Shift up from the top: b trails a by one.
         S_INS_CHK: begin
            if (flags.a_gt_pos) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = AD_B;
               state_in   = S_INS_WR;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = AD_A;
               cmd.wd_sel = WD_VAL;
               cmd.cnt_op = C_INC;
               state_in   = S_SRT0;
            end
         end
         S_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = AD_A;
            cmd.wd_sel = WD_Q;
            cmd.a_op   = A_DEC;
            cmd.b_op   = B_DEC;
            state_in   = S_INS_CHK;
         end
         S_DEL_CHK: begin
            if (flags.b_lt_cnt) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = AD_B;
               state_in   = S_DEL_WR;
            end else begin
               cmd.cnt_op = C_DEC;
               state_in   = S_SRT0;
            end
         end
         S_DEL_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = AD_A;
            cmd.wd_sel = WD_Q;
            cmd.a_op   = A_INC;
            cmd.b_op   = B_INC;
            state_in   = S_DEL_CHK;
         end
         S_RD_REQ: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = AD_A;
            state_in   = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            cmd.read_load = 1'b1;
            state_in      = S_SRT0;
         end
         S_FND_RD: begin
            if (flags.a_lt_cnt) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = AD_A;
               state_in   = S_FND_CMP;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status_val = ST_MISS;
               state_in       = S_SRT0;
            end
         end
         S_FND_CMP: begin
            if (flags.q_eq_val) begin
               cmd.where_load = 1'b1;
               cmd.where_sel  = WH_A;
               state_in       = S_SRT0;
               if (kind_ff == KIND_FIND_TR && flags.a_nz) begin
                  cmd.b_op = B_AM1;
                  state_in = S_SW0;
               end else if (kind_ff == KIND_FIND_MTF) begin
                  cmd.b_op = B_ZERO;
                  state_in = S_SW0;
               end
            end else begin
               cmd.a_op = A_INC;
               state_in = S_FND_RD;
            end
         end
         // Halving walk over [a, b); mid is taken from the pointers.
         S_BIN_CHK: begin
            if (flags.a_lt_b) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = AD_MID;
               state_in   = S_BIN_CMP;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status_val = ST_MISS;
               state_in       = S_SRT0;
            end
         end
         S_BIN_CMP: begin
            if (flags.q_eq_val) begin
               cmd.where_load = 1'b1;
               cmd.where_sel  = WH_MID;
               state_in       = S_SRT0;
            end else if (flags.q_gt_val) begin
               cmd.b_op = B_MID;
               state_in = S_BIN_CHK;
            end else begin
               cmd.a_op = A_MIDP1;
               state_in = S_BIN_CHK;
            end
         end
         S_REV_CHK: begin
            if (flags.rev_go) begin
               cmd.b_op = B_DEC;
               state_in = S_SW0;
            end else begin
               state_in = S_SRT0;
            end
         end
         S_PAR_OUT: begin
            state_in = flags.a_lt_b ? S_PAR_RA : S_SRT0;
         end
         S_PAR_RA: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = AD_A;
            state_in   = S_PAR_CA;
         end
         S_PAR_CA: begin
            if (flags.a_lt_b && flags.q_neg) begin
               cmd.a_op = A_INC;
               state_in = S_PAR_RA;
            end else begin
               state_in = S_PAR_RB;
            end
         end
         S_PAR_RB: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = AD_B;
            state_in   = S_PAR_CB;
         end
         S_PAR_CB: begin
            if (flags.a_lt_b && !flags.q_neg) begin
               cmd.b_op = B_DEC;
               state_in = S_PAR_RB;
            end else if (flags.a_lt_b) begin
               state_in = S_SW0;
            end else begin
               state_in = S_PAR_OUT;
            end
         end
         // Exchange of the entries at a and b.
         S_SW0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = AD_A;
            state_in   = S_SW1;
         end
         S_SW1: begin
            cmd.t1_load = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = AD_B;
            state_in    = S_SW2;
         end
         S_SW2: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = AD_A;
            cmd.wd_sel = WD_Q;
            state_in   = S_SW3;
         end
         S_SW3: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = AD_B;
            cmd.wd_sel = WD_T1;
            if (kind_ff == KIND_REVERSE) begin
               cmd.a_op = A_INC;
               state_in = S_REV_CHK;
            end else if (kind_ff == KIND_PARTIT) begin
               state_in = S_PAR_OUT;
            end else begin
               state_in = S_SRT0;
            end
         end
         // Sorted scan: t1 holds the previous element, q the current one.
         S_SRT0: begin
            cmd.a_op = A_ZERO;
            if (flags.cnt_le1) begin
               cmd.sorted_set = 1'b1;
               cmd.sorted_val = 1'b1;
               state_in       = S_FIN;
            end else begin
               state_in = S_SRT1;
            end
         end
         S_SRT1: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = AD_A;
            cmd.a_op   = A_INC;
            state_in   = S_SRT2;
         end
         S_SRT2: begin
            cmd.t1_load = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = AD_A;
            state_in    = S_SRT3;
         end
         S_SRT3: begin
            if (flags.t1_gt_q) begin
               cmd.sorted_set = 1'b1;
               cmd.sorted_val = 1'b0;
               state_in       = S_FIN;
            end else if (flags.a_p1_lt_cnt) begin
               cmd.t1_load = 1'b1;
               cmd.a_op    = A_INC;
               state_in    = S_SRT4;
            end else begin
               cmd.sorted_set = 1'b1;
               cmd.sorted_val = 1'b1;
               state_in       = S_FIN;
            end
         end
         S_SRT4: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = AD_A;
            state_in   = S_SRT3;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) kind_ff <= req_kind;
   end
endmodule
`default_nettype wire
